### rtl/track_overlay_pixel_compositor_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the track overlay pixel compositor
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef TRACK_OVERLAY_PIXEL_COMPOSITOR_UNIT_MACROS_SVH
`define TRACK_OVERLAY_PIXEL_COMPOSITOR_UNIT_MACROS_SVH

// same-cycle implication
`define TOPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TOPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/topc_pkg.sv
// ----------------------------------------------------------------------------
// topc_pkg
// Types, colors and codes of the track overlay pixel compositor.
// ----------------------------------------------------------------------------
package topc_pkg;

    // RGB565 colors
    localparam logic [15:0] COL_RED     = 16'hF800;
    localparam logic [15:0] COL_BLUE    = 16'h001F;
    localparam logic [15:0] COL_GREEN   = 16'h07E0;
    localparam logic [15:0] COL_YELLOW  = 16'hFFE0;
    localparam logic [15:0] COL_MAGENTA = 16'hF81F;
    localparam logic [15:0] COL_CYAN    = 16'h07FF;

    // configuration register indexes
    localparam logic [2:0] REG_REFERENCE_COL   = 3'd0;
    localparam logic [2:0] REG_TRACK_V2_MODE   = 3'd1;
    localparam logic [2:0] REG_CROSS_ENABLE    = 3'd2;
    localparam logic [2:0] REG_CROSS_LEFT_COL  = 3'd3;
    localparam logic [2:0] REG_CROSS_LEFT_ROW  = 3'd4;
    localparam logic [2:0] REG_CROSS_RIGHT_COL = 3'd5;
    localparam logic [2:0] REG_CROSS_RIGHT_ROW = 3'd6;
    localparam logic [2:0] REG_CROSS_STATUS    = 3'd7;

    localparam logic [7:0] REFERENCE_COL_RESET = 8'd94;

    // midline source codes
    localparam logic [2:0] SRC_BOTH      = 3'd0;
    localparam logic [2:0] SRC_LEFT      = 3'd1;
    localparam logic [2:0] SRC_RIGHT     = 3'd2;
    localparam logic [2:0] SRC_PREDICTED = 3'd3;

    // cross status codes
    localparam logic [1:0] STATUS_NONE     = 2'd0;
    localparam logic [1:0] STATUS_DETECTED = 2'd2;

    // status bar window
    localparam logic [6:0] BAR_ROW_FIRST = 7'd2;
    localparam logic [6:0] BAR_ROW_LAST  = 7'd4;
    localparam logic [7:0] BAR_COL_FIRST = 8'd2;
    localparam logic [7:0] BAR_COL_LAST  = 8'd7;

    typedef struct packed {
        logic [6:0] row;
        logic [7:0] col;
        logic [7:0] gray;
        logic [7:0] edge_l;
        logic       edge_l_ok;
        logic [7:0] edge_r;
        logic       edge_r_ok;
        logic [7:0] center_col;
        logic [2:0] mid_source;
    } t_pixel;

    typedef struct packed {
        logic [7:0] ref_column;
        logic       track_v2_mode;
        logic       cross_enable;
        logic [7:0] mark_l_col;
        logic [7:0] mark_l_row;
        logic [7:0] mark_r_col;
        logic [7:0] mark_r_row;
        logic [1:0] cross_status;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        ref_column:    REFERENCE_COL_RESET,
        track_v2_mode: 1'b0,
        cross_enable:  1'b0,
        mark_l_col:    8'd0,
        mark_l_row:    8'd0,
        mark_r_col:    8'd0,
        mark_r_row:    8'd0,
        cross_status:  STATUS_NONE
    };

endpackage

### rtl/topc_marker_hit.sv
// ----------------------------------------------------------------------------
// topc_marker_hit
// Cross marker coverage test: 5-row stroke plus 5-column bar, clipped.
// ----------------------------------------------------------------------------
module topc_marker_hit #(
    parameter int FRAME_WIDTH = 188
) (
    input  logic [6:0] i_row,
    input  logic [7:0] i_col,
    input  logic [7:0] i_marker_col,
    input  logic [7:0] i_marker_row,
    output logic       o_hit
);

    localparam logic [8:0] FW = 9'(FRAME_WIDTH);

    logic signed [9:0] row_diff;
    logic              row_near;
    logic              row_same;
    logic              col_in;
    logic [8:0]        col_ext;
    logic [8:0]        mcol_ext;

    always_comb begin
        row_diff = signed'({3'b000, i_row}) - signed'({2'b00, i_marker_row});
        row_near = (row_diff >= -10'sd2) && (row_diff <= 10'sd2);
        row_same = (row_diff == 10'sd0);
        col_ext  = {1'b0, i_col};
        mcol_ext = {1'b0, i_marker_col};
        col_in   = col_ext < FW;
        // bar spans mcol-2 .. mcol+2, low end clamped at column 0
        o_hit = row_near && col_in &&
                ((i_col == i_marker_col) ||
                 (row_same && (col_ext + 9'd2 >= mcol_ext) && (col_ext <= mcol_ext + 9'd2)));
    end

endmodule

### rtl/topc_compose.sv
// ----------------------------------------------------------------------------
// topc_compose
// Gray expansion and overlay priority for one pixel.
// ----------------------------------------------------------------------------
module topc_compose #(
    parameter int FRAME_WIDTH = 188
) (
    input  topc_pkg::t_pixel i_pix,
    input  topc_pkg::t_cfg   i_cfg,
    output logic [15:0]      o_rgb565
);

    localparam logic [8:0] FW = 9'(FRAME_WIDTH);

    logic in_frame;
    logic left_hit;
    logic right_hit;
    logic bar_hit;

    topc_marker_hit #(.FRAME_WIDTH(FRAME_WIDTH)) u_left_marker (
        .i_row        (i_pix.row),
        .i_col        (i_pix.col),
        .i_marker_col (i_cfg.mark_l_col),
        .i_marker_row (i_cfg.mark_l_row),
        .o_hit        (left_hit)
    );

    topc_marker_hit #(.FRAME_WIDTH(FRAME_WIDTH)) u_right_marker (
        .i_row        (i_pix.row),
        .i_col        (i_pix.col),
        .i_marker_col (i_cfg.mark_r_col),
        .i_marker_row (i_cfg.mark_r_row),
        .o_hit        (right_hit)
    );

    always_comb begin
        in_frame = {1'b0, i_pix.col} < FW;
        bar_hit  = (i_pix.row >= topc_pkg::BAR_ROW_FIRST) &&
                   (i_pix.row <= topc_pkg::BAR_ROW_LAST) &&
                   (i_cfg.cross_status != topc_pkg::STATUS_NONE) &&
                   (i_pix.col >= topc_pkg::BAR_COL_FIRST) &&
                   (i_pix.col <= topc_pkg::BAR_COL_LAST);

        o_rgb565 = {i_pix.gray[7:3], i_pix.gray[7:2], i_pix.gray[7:3]};
        if (in_frame && i_pix.col == i_cfg.ref_column) begin
            o_rgb565 = topc_pkg::COL_CYAN;
        end
        if (in_frame && i_pix.edge_l_ok && i_pix.col == i_pix.edge_l) begin
            o_rgb565 = topc_pkg::COL_RED;
        end
        if (in_frame && i_pix.edge_r_ok && i_pix.col == i_pix.edge_r) begin
            o_rgb565 = topc_pkg::COL_BLUE;
        end
        if (in_frame && i_pix.col == i_pix.center_col) begin
            // unknown sources leave the pixel alone in v2 mode
            priority if (!i_cfg.track_v2_mode) begin
                o_rgb565 = topc_pkg::COL_GREEN;
            end else if (i_pix.mid_source == topc_pkg::SRC_BOTH) begin
                o_rgb565 = topc_pkg::COL_GREEN;
            end else if (i_pix.mid_source == topc_pkg::SRC_LEFT ||
                         i_pix.mid_source == topc_pkg::SRC_RIGHT) begin
                o_rgb565 = topc_pkg::COL_YELLOW;
            end else if (i_pix.mid_source == topc_pkg::SRC_PREDICTED) begin
                o_rgb565 = topc_pkg::COL_MAGENTA;
            end else begin
                o_rgb565 = o_rgb565;
            end
        end
        if (i_cfg.cross_enable && left_hit) begin
            o_rgb565 = topc_pkg::COL_MAGENTA;
        end
        if (i_cfg.cross_enable && right_hit) begin
            o_rgb565 = topc_pkg::COL_CYAN;
        end
        if (bar_hit) begin
            o_rgb565 = (i_cfg.cross_status == topc_pkg::STATUS_DETECTED) ?
                       topc_pkg::COL_GREEN : topc_pkg::COL_YELLOW;
        end
    end

endmodule

### rtl/track_overlay_pixel_compositor_unit.sv
// ----------------------------------------------------------------------------
// track_overlay_pixel_compositor_unit
// Composites track edge, midline and marker overlays onto a gray pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one pixel per beat: row,
//   column, gray sample and the edge data of that row. Output channel
//   (o_out_valid / i_out_ready) carries one RGB565 pixel per input beat, in
//   order.
//   From input beat to output beat a pixel passes one input register, then
//   the overlay logic feeding the result register. Throughput is one
//   pixel per cycle while the receiver takes every beat.
//   When the receiver stalls, the result register holds its pixel and the
//   input register still takes one more beat; o_in_ready drops only when
//   both stages are full.
//   Configuration (i_cfg_we, i_cfg_addr, i_cfg_data) is taken on the edge
//   where i_cfg_we is high; write it only when the pipe is empty.
//   Synchronous reset empties both stages, sets the reference column to 94
//   and clears the other configuration registers; pixel data is not reset.
// ----------------------------------------------------------------------------
`include "track_overlay_pixel_compositor_unit_macros.svh"

module track_overlay_pixel_compositor_unit #(
    parameter int FRAME_WIDTH = 188
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    // pixel input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [6:0]  i_pixel_row,
    input  logic [7:0]  i_pixel_col,
    input  logic [7:0]  i_pixel_gray,
    input  logic [7:0]  i_left_edge,
    input  logic        i_left_valid,
    input  logic [7:0]  i_right_edge,
    input  logic        i_right_valid,
    input  logic [7:0]  i_mid_line,
    input  logic [2:0]  i_mid_source,
    // pixel output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_pixel_rgb565
);

    topc_pkg::t_cfg   r_cfg;
    topc_pkg::t_pixel r_pix;
    logic             r_s1_valid;
    logic             r_out_valid;
    logic [15:0]      r_rgb565;

    logic             n_s1_valid;
    logic             n_out_valid;
    logic [15:0]      n_rgb565;
    logic             s1_advance;
    logic             in_beat;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= topc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                topc_pkg::REG_REFERENCE_COL:   r_cfg.ref_column    <= i_cfg_data;
                topc_pkg::REG_TRACK_V2_MODE:   r_cfg.track_v2_mode <= i_cfg_data[0];
                topc_pkg::REG_CROSS_ENABLE:    r_cfg.cross_enable  <= i_cfg_data[0];
                topc_pkg::REG_CROSS_LEFT_COL:  r_cfg.mark_l_col    <= i_cfg_data;
                topc_pkg::REG_CROSS_LEFT_ROW:  r_cfg.mark_l_row    <= i_cfg_data;
                topc_pkg::REG_CROSS_RIGHT_COL: r_cfg.mark_r_col    <= i_cfg_data;
                topc_pkg::REG_CROSS_RIGHT_ROW: r_cfg.mark_r_row    <= i_cfg_data;
                topc_pkg::REG_CROSS_STATUS:    r_cfg.cross_status  <= i_cfg_data[1:0];
                default:                       r_cfg               <= r_cfg;
            endcase
        end
    end

    // pipeline handshake
    always_comb begin
        s1_advance  = !r_out_valid || i_out_ready;
        o_in_ready  = !r_s1_valid || s1_advance;
        in_beat     = i_in_valid && o_in_ready;
        n_s1_valid  = in_beat || (r_s1_valid && !s1_advance);
        n_out_valid = s1_advance ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    topc_compose #(.FRAME_WIDTH(FRAME_WIDTH)) u_compose (
        .i_pix    (r_pix),
        .i_cfg    (r_cfg),
        .o_rgb565 (n_rgb565)
    );

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_pix.row        <= i_pixel_row;
            r_pix.col        <= i_pixel_col;
            r_pix.gray       <= i_pixel_gray;
            r_pix.edge_l     <= i_left_edge;
            r_pix.edge_l_ok  <= i_left_valid;
            r_pix.edge_r     <= i_right_edge;
            r_pix.edge_r_ok  <= i_right_valid;
            r_pix.center_col <= i_mid_line;
            r_pix.mid_source <= i_mid_source;
        end
        if (s1_advance && r_s1_valid) begin
            r_rgb565 <= n_rgb565;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_rgb565 = r_rgb565;

    `TOPC_ASSERT_NEXT(a_beat_fills_s1, in_beat, r_s1_valid, "input beat lost at stage 1")
    `TOPC_ASSERT_NEXT(a_s1_moves_out, r_s1_valid && s1_advance, o_out_valid,
                      "stage 1 pixel did not reach the output")
    `TOPC_ASSERT_NOW(a_ready_only_full, !o_in_ready,
                     r_s1_valid && r_out_valid && !i_out_ready,
                     "input stalled while pipe has room")
    `TOPC_ASSERT_NEXT(a_stall_keeps_s1, r_s1_valid && r_out_valid && !i_out_ready,
                      r_s1_valid, "stage 1 pixel dropped during stall")

endmodule
